### design/ncpa_pkg.sv
package ncpa_pkg;

   localparam int PALETTE_SIZE_DEFAULT = 256;

   localparam int COLOUR_W   = 8;
   localparam int DIST_W     = 10;
   localparam int KIND_W     = 2;
   localparam int OUTCOME_W  = 2;
   localparam int PEN_W      = 8;
   localparam int COUNT_IN_W = 9;

   localparam logic [DIST_W-1:0] TOLERANCE_RESET = 10'd3;

   localparam logic [KIND_W-1:0] KIND_PRELOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET_COUNT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MATCH     = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUTCOME_EXACT = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_CLOSE = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_NEW   = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FULL  = 2'd3;

   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } rgb_type;

   localparam int RGB_W = $bits(rgb_type);

endpackage

### design/nearest_colour_pen_allocator.sv
// timing: preload and set-count transactions complete in the accept cycle
// a match scans the n pens in use, one pen per cycle out of the single read
// port of the palette ram, and stops early on an exact hit; no new request is
// accepted until the match result has been loaded into the response register
// reset: synchronous; palette entries read as zero until written, pen count 0
// and tolerance 3
module nearest_colour_pen_allocator #(
   parameter int PALETTE_SIZE = ncpa_pkg::PALETTE_SIZE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [ncpa_pkg::DIST_W-1:0]          csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ncpa_pkg::KIND_W-1:0]          req_kind,
   input  logic [ncpa_pkg::PEN_W-1:0]           req_pen_index,
   input  logic [ncpa_pkg::COUNT_IN_W-1:0]      req_count_value,
   input  logic [ncpa_pkg::COLOUR_W-1:0]        req_red,
   input  logic [ncpa_pkg::COLOUR_W-1:0]        req_green,
   input  logic [ncpa_pkg::COLOUR_W-1:0]        req_blue,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ncpa_pkg::PEN_W-1:0]           rsp_pen,
   output logic [ncpa_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output logic [ncpa_pkg::DIST_W-1:0]          rsp_best_distance
);

   import ncpa_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_SIZE);
   localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PALETTE_SIZE);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [DIST_W-1:0]   tol_ff, tol_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   rgb_type             colour_ff, colour_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_pen_ff, best_pen_in;
   logic [DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PEN_W-1:0]    rsp_pen_ff, rsp_pen_in;
   logic [OUTCOME_W-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [PALETTE_SIZE-1:0] valid_ff;

   logic                accept;
   logic                issue;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   rgb_type             wr_data;
   rgb_type             req_rgb;
   rgb_type             ram_q;
   rgb_type             entry;
   logic [DIST_W-1:0]   distance;
   logic                alloc;
   logic                load_rsp;
   logic [OUTCOME_W-1:0] outcome;

   assign req_rgb   = '{red: req_red, green: req_green, blue: req_blue};
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign issue     = (state_ff == ST_SCAN) && (addr_ff < count_ff);
   // entries never written read as black
   assign entry     = rd_valid_ff ? ram_q : '0;

   ncpa_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_SIZE)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   ncpa_dist_unit u_dist (
      .colour   (colour_ff),
      .entry    (entry),
      .distance (distance)
   );

   always_comb begin
      if (found_ff && (best_dist_ff == '0)) begin
         outcome = OUTCOME_EXACT;
      end else if (found_ff && (best_dist_ff < tol_ff)) begin
         outcome = OUTCOME_CLOSE;
      end else if (count_ff < CNT_FULL) begin
         outcome = OUTCOME_NEW;
      end else begin
         outcome = OUTCOME_FULL;
      end
   end

   assign load_rsp = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ready);
   assign alloc    = load_rsp && (outcome == OUTCOME_NEW);

   always_comb begin
      wr_en   = alloc;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = colour_ff;
      if (accept && (req_kind == KIND_PRELOAD)
          && ({1'b0, req_pen_index} < COUNT_IN_W'(PALETTE_SIZE))) begin
         wr_en   = 1'b1;
         wr_addr = req_pen_index[IDX_W-1:0];
         wr_data = req_rgb;
      end
   end

   always_comb begin
      state_in       = state_ff;
      tol_in         = csr_write_enable ? csr_write_data : tol_ff;
      count_in       = count_ff;
      colour_in      = colour_ff;
      addr_in        = addr_ff;
      pend_in        = issue;
      pend_idx_in    = addr_ff[IDX_W-1:0];
      rd_valid_in    = issue ? valid_ff[addr_ff[IDX_W-1:0]] : rd_valid_ff;
      found_in       = found_ff;
      best_pen_in    = best_pen_ff;
      best_dist_in   = best_dist_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pen_in     = rsp_pen_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_dist_in    = rsp_dist_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_SET_COUNT: begin
                     count_in = (req_count_value > COUNT_IN_W'(PALETTE_SIZE))
                                ? CNT_FULL : CNT_W'(req_count_value);
                  end
                  KIND_MATCH: begin
                     colour_in    = req_rgb;
                     addr_in      = '0;
                     found_in     = 1'b0;
                     best_pen_in  = '0;
                     best_dist_in = '0;
                     state_in     = (count_ff == '0) ? ST_DECIDE : ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            if (pend_ff && (distance == '0)) begin
               // first exact hit ends the scan
               found_in     = 1'b1;
               best_pen_in  = pend_idx_ff;
               best_dist_in = '0;
               state_in     = ST_DECIDE;
            end else begin
               if (pend_ff && (!found_ff || (distance < best_dist_ff))) begin
                  found_in     = 1'b1;
                  best_pen_in  = pend_idx_ff;
                  best_dist_in = distance;
               end
               if (addr_ff == count_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (load_rsp) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome;
               rsp_dist_in    = best_dist_ff;
               if (alloc) begin
                  rsp_pen_in = PEN_W'(count_ff[IDX_W-1:0]);
                  count_in   = count_ff + 1'b1;
               end else begin
                  rsp_pen_in = PEN_W'(best_pen_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= TOLERANCE_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      colour_ff      <= colour_in;
      addr_ff        <= addr_in;
      pend_idx_ff    <= pend_idx_in;
      rd_valid_ff    <= rd_valid_in;
      found_ff       <= found_in;
      best_pen_ff    <= best_pen_in;
      best_dist_ff   <= best_dist_in;
      rsp_pen_ff     <= rsp_pen_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pen           = rsp_pen_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

### design/ncpa_ram.sv
module ncpa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ncpa_dist_unit.sv
module ncpa_dist_unit (
   input  ncpa_pkg::rgb_type             colour,
   input  ncpa_pkg::rgb_type             entry,
   output logic [ncpa_pkg::DIST_W-1:0]   distance
);

   import ncpa_pkg::*;

   logic [COLOUR_W-1:0] diff_r;
   logic [COLOUR_W-1:0] diff_g;
   logic [COLOUR_W-1:0] diff_b;

   always_comb begin
      diff_r = (colour.red > entry.red) ? colour.red - entry.red : entry.red - colour.red;
      diff_g = (colour.green > entry.green) ? colour.green - entry.green
                                            : entry.green - colour.green;
      diff_b = (colour.blue > entry.blue) ? colour.blue - entry.blue
                                          : entry.blue - colour.blue;
      distance = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
   import ncpa_pkg::*;

   localparam int PENS = PALETTE_SIZE_DEFAULT;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 190;

   typedef struct packed {
      logic [PEN_W-1:0]     pen;
      logic [OUTCOME_W-1:0] outcome;
      logic [DIST_W-1:0]    best_distance;
   } pen_choice_type;

   class pen_scoreboard;
      rgb_type           palette [PENS];
      int unsigned       pens_in_use;
      logic [DIST_W-1:0] tolerance;
      pen_choice_type    expected_choices [$];
      int unsigned       errors;

      function new();
         foreach (palette[i]) palette[i] = '0;
         pens_in_use = 0;
         tolerance = TOLERANCE_RESET;
         errors = 0;
      endfunction

      function int unsigned manhattan(rgb_type a, rgb_type b);
         int dr, dg, db;
         dr = int'(a.red) - int'(b.red);
         dg = int'(a.green) - int'(b.green);
         db = int'(a.blue) - int'(b.blue);
         return (dr < 0 ? -dr : dr) + (dg < 0 ? -dg : dg) + (db < 0 ? -db : db);
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [PEN_W-1:0] idx,
                                 logic [COUNT_IN_W-1:0] count, rgb_type colour);
         int unsigned    n, d, best_pen, best_dist;
         bit             found;
         pen_choice_type choice;
         case (kind)
            KIND_PRELOAD: begin
               if (idx < PENS) palette[idx] = colour;
            end
            KIND_SET_COUNT: begin
               pens_in_use = (count > PENS) ? PENS : count;
            end
            KIND_MATCH: begin
               n = pens_in_use;
               found = 1'b0;
               best_pen = 0;
               best_dist = 0;
               for (int i = 0; i < n; i++) begin
                  d = manhattan(colour, palette[i]);
                  // first exact hit ends the scan
                  if (d == 0) begin
                     best_pen = i;
                     best_dist = 0;
                     found = 1'b1;
                     break;
                  end
                  if (!found || d < best_dist) begin
                     best_pen = i;
                     best_dist = d;
                     found = 1'b1;
                  end
               end
               choice.best_distance = DIST_W'(best_dist);
               choice.pen = PEN_W'(best_pen);
               if (found && best_dist == 0) begin
                  choice.outcome = OUTCOME_EXACT;
               end else if (found && best_dist < tolerance) begin
                  choice.outcome = OUTCOME_CLOSE;
               end else if (n < PENS) begin
                  palette[n] = colour;
                  choice.pen = PEN_W'(n);
                  pens_in_use = n + 1;
                  choice.outcome = OUTCOME_NEW;
               end else begin
                  choice.outcome = OUTCOME_FULL;
               end
               expected_choices.push_back(choice);
            end
            default: ;
         endcase
      endfunction

      function void check_response(pen_choice_type got);
         pen_choice_type want;
         if (expected_choices.size() == 0) begin
            $error("unexpected result: pen %0d outcome %0d best_distance %0d",
                   got.pen, got.outcome, got.best_distance);
            errors++;
            return;
         end
         want = expected_choices.pop_front();
         if (got.pen !== want.pen) begin
            $error("pen mismatch: expected %0d, got %0d", want.pen, got.pen);
            errors++;
         end
         if (got.outcome !== want.outcome) begin
            $error("outcome mismatch: expected %0d, got %0d", want.outcome, got.outcome);
            errors++;
         end
         if (got.best_distance !== want.best_distance) begin
            $error("best_distance mismatch: expected %0d, got %0d",
                   want.best_distance, got.best_distance);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [DIST_W-1:0]     csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [PEN_W-1:0]      req_pen_index = '0;
   logic [COUNT_IN_W-1:0] req_count_value = '0;
   logic [COLOUR_W-1:0]   req_red = '0;
   logic [COLOUR_W-1:0]   req_green = '0;
   logic [COLOUR_W-1:0]   req_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PEN_W-1:0]      rsp_pen;
   logic [OUTCOME_W-1:0]  rsp_outcome;
   logic [DIST_W-1:0]     rsp_best_distance;

   pen_scoreboard sb = new();
   bit            stall_enable = 1'b1;
   int unsigned   idle_cycles = 0;

   nearest_colour_pen_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pen_index     (req_pen_index),
      .req_count_value   (req_count_value),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pen           (rsp_pen),
      .rsp_outcome       (rsp_outcome),
      .rsp_best_distance (rsp_best_distance)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // results are checked before the same-edge request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_pen, rsp_outcome, rsp_best_distance});
         if (req_valid && req_ready)
            sb.note_request(req_kind, req_pen_index, req_count_value,
                            {req_red, req_green, req_blue});
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function int unsigned draw_gap();
      return stall_enable ? $urandom_range(0, 15) : 0;
   endfunction

   function logic [COLOUR_W-1:0] nudge(logic [COLOUR_W-1:0] c, int unsigned spread);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return COLOUR_W'(v);
   endfunction

   // when pens are in use, half the matches start from a pen in use, mostly nudged only slightly
   function rgb_type pick_colour();
      rgb_type     c;
      int unsigned spread;
      if (sb.pens_in_use > 0 && $urandom_range(0, 1) == 1) begin
         c = sb.palette[$urandom_range(0, sb.pens_in_use - 1)];
         spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 2);
         c.red = nudge(c.red, spread);
         c.green = nudge(c.green, spread);
         c.blue = nudge(c.blue, spread);
      end else begin
         c = RGB_W'($urandom);
      end
      return c;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task send_request(input logic [KIND_W-1:0] kind, input logic [PEN_W-1:0] idx,
                     input logic [COUNT_IN_W-1:0] count, input rgb_type colour);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind <= kind;
      req_pen_index <= idx;
      req_count_value <= count;
      req_red <= colour.red;
      req_green <= colour.green;
      req_blue <= colour.blue;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // preload and set-count leave no result behind, so idle on after the expected results drain
   task settle();
      req_valid <= 1'b0;
      while (sb.expected_choices.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task write_tolerance(input logic [DIST_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.tolerance = value;
   endtask

   task random_item(output bit counted);
      int unsigned roll, cnt;
      roll = $urandom_range(0, 99);
      counted = 1'b1;
      if (roll < 4) begin
         case ($urandom_range(0, 7))
            0: cnt = PENS;
            1: cnt = $urandom_range(PENS + 1, 511);
            2: cnt = $urandom_range(0, PENS);
            default: cnt = $urandom_range(0, 12);
         endcase
         send_request(KIND_SET_COUNT, PEN_W'($urandom), COUNT_IN_W'(cnt),
                      RGB_W'($urandom));
      end else if (roll < 10) begin
         send_request(KIND_PRELOAD,
                      ($urandom_range(0, 1) == 1)
                         ? PEN_W'($urandom_range(0, sb.pens_in_use + 1))
                         : PEN_W'($urandom),
                      COUNT_IN_W'($urandom), RGB_W'($urandom));
      end else if (roll < 12) begin
         counted = 1'b0;
         send_request(KIND_UNUSED, PEN_W'($urandom), COUNT_IN_W'($urandom),
                      RGB_W'($urandom));
      end else begin
         send_request(KIND_MATCH, PEN_W'($urandom), COUNT_IN_W'($urandom),
                      pick_colour());
      end
   endtask

   initial begin
      int unsigned       gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned       sent;
      bit                counted;
      logic [DIST_W-1:0] tol;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // empty palette, exact, close, just outside tolerance
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd10, 8'd20, 8'd30});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd10, 8'd20, 8'd30});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd12, 8'd20, 8'd30});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd13, 8'd20, 8'd30});
      send_request(KIND_PRELOAD, 8'd255, 9'd0, {8'd255, 8'd255, 8'd255});
      send_request(KIND_PRELOAD, 8'd2, 9'd0, {8'd0, 8'd0, 8'd0});
      // full palette: hit on the last pen, then nearest with no room
      send_request(KIND_SET_COUNT, 8'd0, 9'd256, {8'd0, 8'd0, 8'd0});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd255, 8'd255, 8'd255});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd128, 8'd128, 8'd128});
      send_request(KIND_UNUSED, 8'd255, 9'd511, {8'd255, 8'd255, 8'd255});
      send_request(KIND_SET_COUNT, 8'd0, 9'd511, {8'd0, 8'd0, 8'd0});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd0, 8'd0, 8'd1});
      send_request(KIND_SET_COUNT, 8'd0, 9'd0, {8'd0, 8'd0, 8'd0});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd255, 8'd0, 8'd255});
      send_request(KIND_MATCH, 8'd0, 9'd0, {8'd255, 8'd0, 8'd255});

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: tol = '0;
            1: tol = 10'd766;
            2: tol = 10'd1;
            3: tol = 10'd257;
            4: tol = DIST_W'($urandom_range(0, 766));
            default: tol = DIST_W'($urandom_range(0, 40));
         endcase
         write_tolerance(tol);
         stall_enable = (phase % 3) != 2;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            random_item(counted);
            if (counted) sent++;
         end
      end

      settle();
      repeat (12) @(negedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
